### hdl/iacm_pkg.sv
// package for the i2c adc read / config master
// holds the sequencer step codes, command codes and the item and result structs
// no dependencies
package iacm_pkg;

  // number of bytes clocked in by a read transaction (1 to 8)
  localparam int unsigned READ_BYTES = 4;

  localparam logic [3:0] BYTE_BITS      = 4'd8;
  localparam logic [6:0] DEV_ADDR_RESET = 7'd36;

  // command codes carried in tuser, code three acts as an idle tick
  localparam logic [1:0] FUNC_IDLE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START_A   = 5'd1,
    ST_START_B   = 5'd2,
    ST_START_C   = 5'd3,
    ST_W_LOW     = 5'd4,
    ST_W_DATA    = 5'd5,
    ST_W_HIGH    = 5'd6,
    ST_WA_LOW    = 5'd7,
    ST_WA_REL    = 5'd8,
    ST_WA_HIGH   = 5'd9,
    ST_WA_SAMPLE = 5'd10,
    ST_R_LOW0    = 5'd11,
    ST_R_REL     = 5'd12,
    ST_R_LOW     = 5'd13,
    ST_R_HIGH    = 5'd14,
    ST_RA_LOW    = 5'd15,
    ST_RA_DATA   = 5'd16,
    ST_RA_HIGH   = 5'd17,
    ST_RA_END    = 5'd18,
    ST_STOP_A    = 5'd19,
    ST_STOP_B    = 5'd20,
    ST_STOP_C    = 5'd21
  } step_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] config_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic        addr_nack;
    logic [31:0] read_word;
    logic        done_res;
    logic        busy_res;
    logic        sda_release;
    logic        scl_release;
  } result_t;

endpackage

### hdl/iacm_in_stage.sv
// input register of the i2c adc read / config master
// unpacks the slave stream transfer into an item and holds it until the sequencer takes it
// depends on iacm_pkg
module iacm_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [15:0]    s_axis_tdata,
  input  logic [1:0]     s_axis_tuser,
  input  logic           advance_i,
  output logic           item_valid_o,
  output iacm_pkg::item_t item_o
);
  import iacm_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  take;

  assign s_axis_tready = !valid_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.func        <= s_axis_tuser;
      item_q.config_byte <= s_axis_tdata[7:0];
      item_q.sda_in      <= s_axis_tdata[8];
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hdl/iacm_core.sv
// bus sequencer of the i2c adc read / config master
// one line-level step per item: step register, shifters, counters, line levels, result word
// depends on iacm_pkg
module iacm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              step_en_i,
  input  iacm_pkg::item_t   item_i,
  output iacm_pkg::result_t res_o
);
  import iacm_pkg::*;

  step_e       step_q, step_d, cur_step;
  logic [6:0]  dev_addr_q;
  logic [3:0]  bit_q, bit_d;
  logic [2:0]  byte_q, byte_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  tx_q, tx_d;
  logic        wr_q, wr_d;
  logic        nack_q, nack_d;
  logic [31:0] word_q, word_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        busy, done;
  logic        start_cmd;
  logic [3:0]  bit_inc;
  logic        last_byte;

  assign start_cmd = (step_q == ST_IDLE) &&
                     (item_i.func == FUNC_READ || item_i.func == FUNC_WRITE);
  assign cur_step  = start_cmd ? ST_START_A : step_q;
  assign bit_inc   = bit_q + 4'd1;
  assign last_byte = ({1'b0, byte_q} + 4'd1) >= 4'(READ_BYTES);

  // next step
  always_comb begin
    case (cur_step)
      ST_IDLE:      step_d = ST_IDLE;
      ST_START_A:   step_d = ST_START_B;
      ST_START_B:   step_d = ST_START_C;
      ST_START_C:   step_d = ST_W_LOW;
      ST_W_LOW:     step_d = ST_W_DATA;
      ST_W_DATA:    step_d = ST_W_HIGH;
      ST_W_HIGH:    step_d = (bit_inc >= BYTE_BITS) ? ST_WA_LOW : ST_W_LOW;
      ST_WA_LOW:    step_d = ST_WA_REL;
      ST_WA_REL:    step_d = ST_WA_HIGH;
      ST_WA_HIGH:   step_d = ST_WA_SAMPLE;
      ST_WA_SAMPLE: begin
        if (byte_q != 3'd0 || item_i.sda_in) begin
          step_d = ST_STOP_A;
        end else if (wr_q) begin
          step_d = ST_W_LOW;
        end else begin
          step_d = ST_R_LOW0;
        end
      end
      ST_R_LOW0:    step_d = ST_R_REL;
      ST_R_REL:     step_d = ST_R_LOW;
      ST_R_LOW:     step_d = ST_R_HIGH;
      ST_R_HIGH:    step_d = (bit_inc >= BYTE_BITS) ? ST_RA_LOW : ST_R_LOW;
      ST_RA_LOW:    step_d = ST_RA_DATA;
      ST_RA_DATA:   step_d = ST_RA_HIGH;
      ST_RA_HIGH:   step_d = ST_RA_END;
      ST_RA_END:    step_d = last_byte ? ST_STOP_A : ST_R_LOW0;
      ST_STOP_A:    step_d = ST_STOP_B;
      ST_STOP_B:    step_d = ST_STOP_C;
      ST_STOP_C:    step_d = ST_IDLE;
      default:      step_d = ST_IDLE;
    endcase
  end

  // line levels and datapath
  always_comb begin
    bit_d  = bit_q;
    byte_d = byte_q;
    shift_d = shift_q;
    tx_d   = tx_q;
    wr_d   = wr_q;
    nack_d = nack_q;
    word_d = word_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    busy   = 1'b1;
    done   = 1'b0;
    if (start_cmd) begin
      wr_d    = (item_i.func == FUNC_WRITE);
      tx_d    = {dev_addr_q, ~wr_d};
      shift_d = wr_d ? {24'd0, item_i.config_byte} : 32'd0;
      nack_d  = 1'b0;
      word_d  = 32'd0;
      bit_d   = 4'd0;
      byte_d  = 3'd0;
    end
    case (cur_step)
      ST_IDLE: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        busy  = 1'b0;
      end
      ST_START_A: sda_d = 1'b1;
      ST_START_B: scl_d = 1'b1;
      ST_START_C: sda_d = 1'b0;
      ST_W_LOW:   scl_d = 1'b0;
      ST_W_DATA:  sda_d = tx_q[7];
      ST_W_HIGH: begin
        scl_d = 1'b1;
        tx_d  = {tx_q[6:0], 1'b0};
        bit_d = bit_inc;
      end
      ST_WA_LOW:  scl_d = 1'b0;
      ST_WA_REL:  sda_d = 1'b1;
      ST_WA_HIGH: scl_d = 1'b1;
      ST_WA_SAMPLE: begin
        scl_d = 1'b0;
        bit_d = 4'd0;
        if (byte_q != 3'd0) begin
          // data byte ack of a write is ignored
        end else if (item_i.sda_in) begin
          nack_d = 1'b1;
        end else if (wr_q) begin
          tx_d   = shift_q[7:0];
          byte_d = 3'd1;
        end else begin
          shift_d = 32'd0;
        end
      end
      ST_R_LOW0: begin
        scl_d = 1'b0;
        bit_d = 4'd0;
      end
      ST_R_REL: sda_d = 1'b1;
      ST_R_LOW: begin
        scl_d = 1'b0;
        if (bit_q != 4'd0) begin
          shift_d = {shift_q[30:0], item_i.sda_in};
        end
      end
      ST_R_HIGH: begin
        scl_d = 1'b1;
        bit_d = bit_inc;
      end
      ST_RA_LOW: begin
        scl_d   = 1'b0;
        shift_d = {shift_q[30:0], item_i.sda_in};
      end
      ST_RA_DATA: sda_d = last_byte;
      ST_RA_HIGH: scl_d = 1'b1;
      ST_RA_END: begin
        scl_d = 1'b0;
        if (!last_byte) begin
          byte_d = byte_q + 3'd1;
        end
      end
      ST_STOP_A: sda_d = 1'b0;
      ST_STOP_B: scl_d = 1'b1;
      ST_STOP_C: begin
        sda_d  = 1'b1;
        done   = 1'b1;
        word_d = (wr_q || nack_q) ? 32'd0 : shift_q;
      end
      default: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        busy  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_IDLE;
      dev_addr_q <= DEV_ADDR_RESET;
      bit_q      <= 4'd0;
      byte_q     <= 3'd0;
      shift_q    <= 32'd0;
      tx_q       <= 8'd0;
      wr_q       <= 1'b0;
      nack_q     <= 1'b0;
      word_q     <= 32'd0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      if (step_en_i) begin
        step_q  <= step_d;
        bit_q   <= bit_d;
        byte_q  <= byte_d;
        shift_q <= shift_d;
        tx_q    <= tx_d;
        wr_q    <= wr_d;
        nack_q  <= nack_d;
        word_q  <= word_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
      end
    end
  end

  assign res_o.scl_release = scl_d;
  assign res_o.sda_release = sda_d;
  assign res_o.busy_res    = busy;
  assign res_o.done_res    = done;
  assign res_o.read_word   = word_d;
  assign res_o.addr_nack   = nack_d;

`ifndef NO_ASSERTIONS
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && done |=> step_q == ST_IDLE)
    else $error("sequencer not idle after stop");
  a_nack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nack_q |-> word_q == 32'd0)
    else $error("nonzero read word after address nack");
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> scl_d && sda_d)
    else $error("bus lines driven while idle");
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BYTE_BITS)
    else $error("bit counter past one byte");
`endif

endmodule

### hdl/i2c_adc_read_config_master.sv
// top level of the i2c adc read / config master
// joins the input register, the bus sequencer and the result register
// depends on iacm_pkg, iacm_in_stage, iacm_core
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: config_byte, sda_in; tuser: func
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: scl, sda, busy, done, word, nack
// cfg       in         cfg_we_i                     cfg_wdata_i: device_address
//
// one transfer in gives one transfer out, one bus tick per transfer, one per clock while m_axis is not stalled
// an item passes the input register, then the step logic into the result register
// the sequencer step register closes the only loop and advances once per item
// a stall on m_axis holds the result register and the input register, and after
// both are full s_axis_tready drops; no internal reset pass, ready right after reset
module i2c_adc_read_config_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config_byte [7:0], sda_in [8], zero [15:9]
  input  logic [15:0] s_axis_tdata,
  // func [1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // scl_release [0], sda_release [1], busy_res [2], done_res [3],
  // read_word [35:4], addr_nack [36], zero [39:37]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);
  import iacm_pkg::*;

  logic    item_valid;
  item_t   item;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    out_valid_d;
  logic    advance;
  logic    step_en;

  // result register free or being emptied this cycle
  assign advance = !out_valid_q || m_axis_tready;
  assign step_en = item_valid && advance;

  iacm_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance_i     (advance),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  iacm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_en_i   (step_en),
    .item_i      (item),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.addr_nack, res_q.read_word, res_q.done_res,
                          res_q.busy_res, res_q.sda_release, res_q.scl_release};

`ifndef NO_ASSERTIONS
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q && !m_axis_tready && item_valid)
    else $error("input stalled without a full pipeline");
`endif

endmodule
